// ----- rtl/ttbc_pkg.sv -----
// ttbc_pkg: shared types and constants of the table tag balance counter
// transaction payload structs, window struct between the byte cells and the tag counters
// no dependencies
package ttbc_pkg;

   localparam int BYTE_W      = 8;
   localparam int PATTERN_W   = 64;
   localparam int NUM_TAGS    = 8;
   localparam int WINDOW_SPAN = 8;    // current byte plus seven held bytes
   localparam int OUT_COUNT_W = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int MAX_LEN     = 8;

   // register indexes, one per tag
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_OPEN   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_CLOSE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_OPEN     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_CLOSE    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_OPEN  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_CLOSE = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_OPEN    = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_CLOSE   = 4'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_W-1:0] table_open_count;
      logic [OUT_COUNT_W-1:0] table_close_count;
      logic [OUT_COUNT_W-1:0] row_open_count;
      logic [OUT_COUNT_W-1:0] row_close_count;
      logic [OUT_COUNT_W-1:0] header_open_count;
      logic [OUT_COUNT_W-1:0] header_close_count;
      logic [OUT_COUNT_W-1:0] data_open_count;
      logic [OUT_COUNT_W-1:0] data_close_count;
      logic                   balanced;
   } rsp_type;

   // bytes[k] is the byte k positions before the current one
   typedef struct packed {
      logic [WINDOW_SPAN-1:0][BYTE_W-1:0] bytes;
      logic [WINDOW_SPAN-1:0]             valid;
   } window_type;

   // pattern lengths outside 1..8 are pulled into range
   function automatic int clamp_len(int v);
      int r;
      r = v;
      if (v < 1) r = 1;
      if (v > MAX_LEN) r = MAX_LEN;
      return r;
   endfunction

endpackage

// ----- rtl/ttbc_byte_cell.sv -----
// ttbc_byte_cell: one stage of the byte window shift line
// holds a byte and its valid flag, takes its neighbor's on each transaction
// depends on ttbc_pkg
module ttbc_byte_cell
   import ttbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  logic [BYTE_W-1:0] byte_prev,
   input  logic              valid_prev,
   output logic [BYTE_W-1:0] byte_out,
   output logic              valid_out
);

   logic [BYTE_W-1:0] byte_ff;
   logic              valid_ff;
   logic              valid_in;

   // end of string empties the cell
   assign valid_in = shift ? (valid_prev & ~clear) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload byte, no reset needed
   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= byte_prev;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

// ----- rtl/ttbc_tag_counter.sv -----
// ttbc_tag_counter: pattern compare and saturating occurrence counter for one tag
// compares the low LEN octets of its pattern against the byte window
// depends on ttbc_pkg
module ttbc_tag_counter
   import ttbc_pkg::*;
#(
   parameter int LEN         = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   last,
   input  window_type             window,
   input  logic [PATTERN_W-1:0]   pattern,
   output logic [COUNT_WIDTH-1:0] count_upd
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   hit;

   // every used octet must equal its window byte, oldest byte first
   always_comb begin
      hit = window.valid[LEN-1];
      for (int j = 0; j < LEN; j++) begin
         if (pattern[j*BYTE_W +: BYTE_W] != window.bytes[LEN-1-j]) begin
            hit = 1'b0;
         end
      end
   end

   // saturating increment
   assign count_upd = (hit && (count_ff != {COUNT_WIDTH{1'b1}})) ?
                      count_ff + COUNT_WIDTH'(1) : count_ff;

   // counts restart with each string
   assign count_in = !accept ? count_ff :
                     last    ? '0       : count_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/table_tag_balance_counter_unit.sv -----
// table_tag_balance_counter_unit: top level of the table tag balance counter
// a seven-cell byte window chain feeding eight tag counters, plus result register
// depends on ttbc_pkg, ttbc_byte_cell, ttbc_tag_counter
//
// Usage: a string enters on the req_ channel one byte per transaction, with
// last_byte set on its final byte. Eight 64-bit tag patterns are written on
// the csr_ port (index 0..7, other indexes ignored) while the block is idle.
// Each byte is compared in the cycle it is accepted against all patterns over
// a window of the seven previous bytes, and the matching counters advance.
// Throughput is one byte per cycle unless a waiting result holds input off;
// the compare and count update of a byte finish in the cycle it is taken.
// The byte marked last produces one rsp_ transaction in the following cycle
// with the eight counts and the balance flag, and the window and counters
// clear so the next string starts from zero.
// If the receiver stalls while a result waits, input is held off until the
// result is taken; with rsp_ready high the input never stalls.
// Reset clears the patterns, counters, window and the result valid.
module table_tag_balance_counter_unit
   import ttbc_pkg::*;
#(
   parameter int TABLE_OPEN_LEN  = 7,
   parameter int TABLE_CLOSE_LEN = 8,
   parameter int CELL_OPEN_LEN   = 4,
   parameter int CELL_CLOSE_LEN  = 5,
   parameter int COUNT_WIDTH     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0]   csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   localparam int TO_LEN = clamp_len(TABLE_OPEN_LEN);
   localparam int TC_LEN = clamp_len(TABLE_CLOSE_LEN);
   localparam int CO_LEN = clamp_len(CELL_OPEN_LEN);
   localparam int CC_LEN = clamp_len(CELL_CLOSE_LEN);
   localparam int TAG_W  = $clog2(NUM_TAGS);

   logic [NUM_TAGS-1:0][PATTERN_W-1:0]   pattern_ff;
   logic [NUM_TAGS-1:0][COUNT_WIDTH-1:0] count_upd;
   window_type                           window;
   logic                                 accept;
   logic                                 last;
   logic                                 balanced;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   rsp_type                              rsp_data_ff;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign last      = req_data.last_byte;

   // pattern registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
      end else if (csr_write_en && (csr_index <= REG_DATA_CLOSE)) begin
         pattern_ff[csr_index[TAG_W-1:0]] <= csr_wdata;
      end
   end

   // window head is the incoming byte
   assign window.bytes[0] = req_data.byte_in;
   assign window.valid[0] = 1'b1;

   // byte window chain
   for (genvar k = 1; k < WINDOW_SPAN; k++) begin : g_cell
      ttbc_byte_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (accept),
         .clear      (last),
         .byte_prev  (window.bytes[k-1]),
         .valid_prev (window.valid[k-1]),
         .byte_out   (window.bytes[k]),
         .valid_out  (window.valid[k])
      );
   end

   // one counter per tag; even tags are openings, odd are closings
   for (genvar t = 0; t < NUM_TAGS; t++) begin : g_tag
      localparam int LEN = (t == int'(REG_TABLE_OPEN))  ? TO_LEN :
                           (t == int'(REG_TABLE_CLOSE)) ? TC_LEN :
                           ((t % 2) == 0)               ? CO_LEN : CC_LEN;
      ttbc_tag_counter #(
         .LEN         (LEN),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_counter (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .last      (last),
         .window    (window),
         .pattern   (pattern_ff[t]),
         .count_upd (count_upd[t])
      );
   end

   // balance over the full-width counts
   assign balanced =
      (count_upd[REG_TABLE_OPEN[TAG_W-1:0]]  == count_upd[REG_TABLE_CLOSE[TAG_W-1:0]])  &&
      (count_upd[REG_ROW_OPEN[TAG_W-1:0]]    == count_upd[REG_ROW_CLOSE[TAG_W-1:0]])    &&
      (count_upd[REG_HEADER_OPEN[TAG_W-1:0]] == count_upd[REG_HEADER_CLOSE[TAG_W-1:0]]) &&
      (count_upd[REG_DATA_OPEN[TAG_W-1:0]]   == count_upd[REG_DATA_CLOSE[TAG_W-1:0]]);

   // result register valid
   assign rsp_valid_in = (accept && last) ? 1'b1 :
                         rsp_ready        ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on the last byte of a string
   always_ff @(posedge clock) begin
      if (accept && last) begin
         rsp_data_ff.table_open_count   <=
            OUT_COUNT_W'(count_upd[REG_TABLE_OPEN[TAG_W-1:0]]);
         rsp_data_ff.table_close_count  <=
            OUT_COUNT_W'(count_upd[REG_TABLE_CLOSE[TAG_W-1:0]]);
         rsp_data_ff.row_open_count     <=
            OUT_COUNT_W'(count_upd[REG_ROW_OPEN[TAG_W-1:0]]);
         rsp_data_ff.row_close_count    <=
            OUT_COUNT_W'(count_upd[REG_ROW_CLOSE[TAG_W-1:0]]);
         rsp_data_ff.header_open_count  <=
            OUT_COUNT_W'(count_upd[REG_HEADER_OPEN[TAG_W-1:0]]);
         rsp_data_ff.header_close_count <=
            OUT_COUNT_W'(count_upd[REG_HEADER_CLOSE[TAG_W-1:0]]);
         rsp_data_ff.data_open_count    <=
            OUT_COUNT_W'(count_upd[REG_DATA_OPEN[TAG_W-1:0]]);
         rsp_data_ff.data_close_count   <=
            OUT_COUNT_W'(count_upd[REG_DATA_CLOSE[TAG_W-1:0]]);
         rsp_data_ff.balanced           <= balanced;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
